// ----- hw/rtl/dwbp_pkg.sv -----
// ============================================================================
// dwbp_pkg
// Shared types and fixed field widths for the dedup window block picker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dwbp_pkg;

    // Fixed widths of the request and result fields.
    localparam int CLASS_W  = 4;
    localparam int RND_W    = 32;
    localparam int COMP_W   = 7;
    localparam int ID_W     = 64;

    // The serial remainder unit consumes one hex digit of the random value per cycle.
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = RND_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK   = 5'b00010,
        S_MOD    = 5'b00100,
        S_READ   = 5'b01000,
        S_UPDATE = 5'b10000
    } state_t;

    // One window entry as held in the entry memory.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CLASS_W-1:0] uses;
        logic [COMP_W-1:0]  comp;
    } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dwbp_mod_unit.sv -----
// ============================================================================
// dwbp_mod_unit
// Digit-serial remainder of a 32-bit value by a constant divisor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dwbp_mod_unit #(
    parameter int DIVISOR = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    input  wire logic [dwbp_pkg::RND_W-1:0]              dividend,
    output logic                                         done,
    output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] remainder
);

    localparam int RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
    localparam int AW = RW + dwbp_pkg::DIGIT_W;
    localparam logic [AW-1:0] DIV_AW = AW'(DIVISOR);

    logic [dwbp_pkg::RND_W-1:0]       shift_reg, shift_next;
    logic [RW-1:0]                    rem_reg, rem_next;
    logic [dwbp_pkg::DIGIT_CNT_W-1:0] dig_reg, dig_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [AW-1:0]                    acc_work;

    // Fold in the next digit, then reduce below the divisor in four
    // conditional subtract steps (the sum is always below 16 times the divisor).
    always_comb
    begin
        acc_work = {rem_reg, shift_reg[dwbp_pkg::RND_W-1 -: dwbp_pkg::DIGIT_W]};
        for (int k = 3; k >= 0; k--)
        begin
            if (acc_work >= (DIV_AW << k))
            begin
                acc_work = acc_work - (DIV_AW << k);
            end
        end
    end

    // Digit sequencing.
    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dig_next   = dig_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            dig_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg << dwbp_pkg::DIGIT_W;
            rem_next   = acc_work[RW-1:0];
            dig_next   = dig_reg + 1'b1;
            if (dig_reg == dwbp_pkg::DIGIT_CNT_W'(dwbp_pkg::NUM_DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dig_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            dig_reg  <= dig_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dedup_window_block_picker_unit.sv -----
// ============================================================================
// dedup_window_block_picker_unit
// Picks a fresh or a reused block id for each request of a dedup generator.
// ============================================================================
// Usage: requests arrive on the s_axis channel, one per transaction; each
// yields exactly one result transaction on the m_axis channel.
// Class 0, or a class at or above NUM_CLASSES, takes a fresh id from a
// 64-bit counter. A class whose window is not full also takes a fresh id
// and appends an entry. A class whose window is full reuses the entry at
// random_pick mod WINDOW_DEPTH, and retires it when its uses run out.
// Path to the earliest result transaction: a lookup and the output register for
// a fresh id; a reuse adds the digit-serial remainder unit (one hex digit of
// random_pick at a time), its done flag, one entry memory read and one update.
// One request is in work at a time, so a new one is accepted only once the
// previous one has left the sequencer; s_axis_tready is high only while idle.
// The result sits in an output register, so the next request is accepted
// while the receiver stalls; a finished result is held in the sequencer
// until the previous one has been taken.
// Reset clears the id counter and every window count; the entry memory
// needs no clearing, since only filled slots are ever read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dedup_window_block_picker_unit #(
    parameter int WINDOW_DEPTH = 8,
    parameter int NUM_CLASSES  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] repeat_class, [35:4] random_pick, [42:36] new_compression, [47:43] zero
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [63:0] pick_id, [70:64] compression, [71] zero
    output logic [71:0]      m_axis_tdata,
    // [0] reused, [1] retired
    output logic [1:0]       m_axis_tuser
);

    localparam int CLASS_SLOTS = (NUM_CLASSES < 16) ? NUM_CLASSES : 16;
    localparam int CLS_IDX_W   = $clog2(CLASS_SLOTS);
    localparam int SLOTS       = CLASS_SLOTS * WINDOW_DEPTH;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [31:0] NUM_CLASSES_W = 32'(NUM_CLASSES);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_DEPTH);

    dwbp_pkg::state_t state_reg, state_next;

    // Captured request.
    logic [dwbp_pkg::CLASS_W-1:0] cls_reg;
    logic [dwbp_pkg::RND_W-1:0]   rnd_reg;
    logic [dwbp_pkg::COMP_W-1:0]  comp_reg;
    logic                         windowed_reg;
    logic                         in_accept;
    logic                         in_windowed;

    // Id counter and window counts.
    logic [dwbp_pkg::ID_W-1:0] next_id_reg;
    logic                      id_take;
    logic [CNT_W-1:0]          count_reg [CLASS_SLOTS];
    logic                      cnt_inc, cnt_dec;

    // Entry memory with one write and two registered read ports.
    dwbp_pkg::entry_t entry_mem [SLOTS];
    dwbp_pkg::entry_t rd_pick_reg, rd_last_reg;
    logic             mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    dwbp_pkg::entry_t mem_wdata;

    // Output register.
    logic                        out_valid_reg;
    logic [dwbp_pkg::ID_W-1:0]   out_id_reg;
    logic [dwbp_pkg::COMP_W-1:0] out_comp_reg;
    logic                        out_reused_reg, out_retired_reg;
    logic                        out_free, out_load;
    logic [dwbp_pkg::ID_W-1:0]   out_id_d;
    logic [dwbp_pkg::COMP_W-1:0] out_comp_d;
    logic                        out_reused_d, out_retired_d;

    // Addressing.
    logic [CLS_IDX_W-1:0] cls_idx;
    logic [CNT_W-1:0]     count_cur;
    logic                 win_full;
    logic [SLOT_W-1:0]    base_slot, fill_slot, pick_slot, last_slot;
    logic [dwbp_pkg::CLASS_W-1:0] left_dec;

    // Remainder unit.
    logic             mod_start, mod_done;
    logic [POS_W-1:0] mod_rem;

    dwbp_mod_unit #(
        .DIVISOR (WINDOW_DEPTH)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (rnd_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Input handshake and class decode.
    assign s_axis_tready = (state_reg == dwbp_pkg::S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_windowed   = (s_axis_tdata[3:0] != '0)
                        && (32'(s_axis_tdata[3:0]) < NUM_CLASSES_W);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cls_reg      <= s_axis_tdata[3:0];
            rnd_reg      <= s_axis_tdata[35:4];
            comp_reg     <= s_axis_tdata[42:36];
            windowed_reg <= in_windowed;
        end
    end

    // Slot addresses inside the selected class's window.
    assign cls_idx   = cls_reg[CLS_IDX_W-1:0];
    assign count_cur = count_reg[cls_idx];
    assign win_full  = (count_cur == FULL_CNT);
    assign base_slot = SLOT_W'(SLOT_W'(cls_idx) * SLOT_W'(WINDOW_DEPTH));
    assign fill_slot = base_slot + SLOT_W'(count_cur);
    assign pick_slot = base_slot + SLOT_W'(mod_rem);
    assign last_slot = base_slot + SLOT_W'(WINDOW_DEPTH - 1);
    assign left_dec  = rd_pick_reg.uses - 1'b1;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Sequencer and the actions of each step.
    always_comb
    begin
        state_next    = state_reg;
        mod_start     = 1'b0;
        id_take       = 1'b0;
        cnt_inc       = 1'b0;
        cnt_dec       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = fill_slot;
        mem_wdata     = '{id: next_id_reg, uses: cls_reg, comp: comp_reg};
        out_load      = 1'b0;
        out_id_d      = next_id_reg;
        out_comp_d    = comp_reg;
        out_reused_d  = 1'b0;
        out_retired_d = 1'b0;
        unique case (state_reg)
            dwbp_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = dwbp_pkg::S_LOOK;
                end
            end
            dwbp_pkg::S_LOOK:
            begin
                if (windowed_reg && win_full)
                begin
                    mod_start  = 1'b1;
                    state_next = dwbp_pkg::S_MOD;
                end
                else if (out_free)
                begin
                    // Fresh id; a windowed class also appends an entry.
                    out_load   = 1'b1;
                    id_take    = 1'b1;
                    mem_we     = windowed_reg;
                    cnt_inc    = windowed_reg;
                    state_next = dwbp_pkg::S_IDLE;
                end
            end
            dwbp_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = dwbp_pkg::S_READ;
                end
            end
            dwbp_pkg::S_READ:
            begin
                state_next = dwbp_pkg::S_UPDATE;
            end
            dwbp_pkg::S_UPDATE:
            begin
                mem_waddr = pick_slot;
                if (left_dec == '0)
                begin
                    mem_wdata = rd_last_reg;
                end
                else
                begin
                    mem_wdata = '{id: rd_pick_reg.id, uses: left_dec,
                                  comp: rd_pick_reg.comp};
                end
                out_id_d      = rd_pick_reg.id;
                out_comp_d    = rd_pick_reg.comp;
                out_reused_d  = 1'b1;
                out_retired_d = (left_dec == '0);
                if (out_free)
                begin
                    out_load   = 1'b1;
                    mem_we     = 1'b1;
                    cnt_dec    = (left_dec == '0);
                    state_next = dwbp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dwbp_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dwbp_pkg::S_IDLE;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CLASS_SLOTS; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (id_take)
            begin
                next_id_reg <= next_id_reg + 64'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cnt_inc)
            begin
                count_reg[cls_idx] <= count_cur + CNT_W'(1);
            end
            else if (cnt_dec)
            begin
                count_reg[cls_idx] <= count_cur - CNT_W'(1);
            end
        end
    end

    // Entry memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == dwbp_pkg::S_READ)
        begin
            rd_pick_reg <= entry_mem[pick_slot];
            rd_last_reg <= entry_mem[last_slot];
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_id_reg      <= out_id_d;
            out_comp_reg    <= out_comp_d;
            out_reused_reg  <= out_reused_d;
            out_retired_reg <= out_retired_d;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_comp_reg, out_id_reg};
    assign m_axis_tuser  = {out_retired_reg, out_reused_reg};

    // A window never holds more entries than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dwbp_pkg::S_LOOK) && windowed_reg |-> count_cur <= FULL_CNT)
        else $error("window count exceeds depth");

    // The remainder unit finishes only while the sequencer waits for it.
    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == dwbp_pkg::S_MOD)
        else $error("remainder done outside of its wait state");

    // A completed reuse step presents a reused result next cycle.
    a_reuse_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dwbp_pkg::S_UPDATE) && out_free
        |=> m_axis_tvalid && m_axis_tuser[0])
        else $error("reuse result missing");

    // A retired flag only ever accompanies a reused result.
    a_retire_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("retired result without reuse");

endmodule

`default_nettype wire
